// File: rtl/core/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// shared types, codes and helper functions of the infix to postfix converter
// ----------------------------------------------------------------------------
`default_nettype none

package i2p_pkg;

   localparam int STACK_DEPTH_DEF = 32;
   localparam int QUEUE_DEPTH     = 2;

   localparam int FUNC_W     = 3;
   localparam int OP_W       = 3;
   localparam int REF_W      = 32;
   localparam int KIND_W     = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // token kinds on the request side
   localparam logic [FUNC_W-1:0] FUNC_OPND = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_OPER = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LBR  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_RBR  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_END  = 3'd4;

   // operator codes, also the stack entry codes
   localparam logic [OP_W-1:0] OP_PLUS   = 3'd0;
   localparam logic [OP_W-1:0] OP_MINUS  = 3'd1;
   localparam logic [OP_W-1:0] OP_TIMES  = 3'd2;
   localparam logic [OP_W-1:0] OP_DIVIDE = 3'd3;
   localparam logic [OP_W-1:0] OP_POWER  = 3'd4;
   localparam logic [OP_W-1:0] OP_NEG    = 3'd5;
   localparam logic [OP_W-1:0] OP_LBR    = 3'd6;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_OPND = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OPER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

   localparam logic [1:0] PRIO_LOW  = 2'd0;
   localparam logic [1:0] PRIO_MID  = 2'd1;
   localparam logic [1:0] PRIO_HIGH = 2'd2;

   typedef enum logic [2:0] {
      CMD_OPND = 3'd0,
      CMD_OPER = 3'd1,
      CMD_LBR  = 3'd2,
      CMD_RBR  = 3'd3,
      CMD_END  = 3'd4
   } cmd_code_type;

   typedef struct packed {
      cmd_code_type     code;
      logic [OP_W-1:0]  op;
      logic [REF_W-1:0] opnd;
   } cmd_type;

   function automatic logic [1:0] prio(input logic [OP_W-1:0] op);
      logic [1:0] p;
      if (op <= OP_MINUS) begin
         p = PRIO_LOW;
      end else if (op <= OP_DIVIDE) begin
         p = PRIO_MID;
      end else begin
         p = PRIO_HIGH;
      end
      return p;
   endfunction

   // true when the stack top has to leave before new_op goes on
   function automatic logic pops(input logic [OP_W-1:0] new_op, input logic [OP_W-1:0] top);
      logic [1:0] p;
      logic [1:0] tp;
      logic       r;
      p  = prio(new_op);
      tp = prio(top);
      if (top == OP_LBR) begin
         r = 1'b0;
      end else if (p == PRIO_HIGH) begin
         r = (p < tp);
      end else begin
         r = (p <= tp);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/infix_to_postfix_converter.sv
// an operand beat passes through the command queue, the command register and
//   the result register before it shows on rsp; the stack engine runs one
//   command at a time, waiting on its registered memory read after each stack move
// the front end keeps taking beats while the two-entry command queue has room
// reset: synchronous, active high; clears the queue, the stack count, the
//   error flag and the result valid flag; stack memory contents are not cleared
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard converter: infix tokens in, postfix tokens out
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [i2p_pkg::REQ_DATA_W-1:0]  req_tdata,  // op_symbol, operand_ref
   input  wire logic [i2p_pkg::FUNC_W-1:0]      req_tuser,  // func
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [i2p_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // out_op, out_ref
   output logic [i2p_pkg::KIND_W-1:0]           rsp_tuser,  // out_kind
   output logic                                 rsp_tlast
);

   i2p_pkg::cmd_type wr_cmd;
   i2p_pkg::cmd_type rd_cmd;
   logic             q_wr_en;
   logic             q_full;
   logic             q_rd_en;
   logic             q_valid;

   i2p_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_wr_en    (q_wr_en),
      .q_wr_data  (wr_cmd)
   );

   i2p_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_wr_en),
      .wr_data  (wr_cmd),
      .full     (q_full),
      .rd_en    (q_rd_en),
      .rd_data  (rd_cmd),
      .rd_valid (q_valid)
   );

   i2p_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (rd_cmd),
      .q_rd_en    (q_rd_en),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: rtl/core/i2p_front.sv
// ----------------------------------------------------------------------------
// i2p_front
// accepts request beats, drops bad tokens, resolves unary minus, and queues
// one command per useful token
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [i2p_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic [i2p_pkg::FUNC_W-1:0]          req_tuser,
   input  wire logic                                q_full,
   output logic                                     q_wr_en,
   output i2p_pkg::cmd_type                         q_wr_data
);

   typedef enum logic [4:0] {
      PREV_NONE = 5'b00001,
      PREV_OPND = 5'b00010,
      PREV_OPER = 5'b00100,
      PREV_LBR  = 5'b01000,
      PREV_RBR  = 5'b10000
   } prev_kind_type;

   prev_kind_type prev_ff, prev_in;

   logic [i2p_pkg::FUNC_W-1:0] func;
   logic [i2p_pkg::OP_W-1:0]   sym;
   logic                       tok_ok;
   logic                       take;
   logic                       unary;

   assign func       = req_tuser;
   assign sym        = req_tdata[i2p_pkg::OP_W-1:0];
   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   // unknown kinds and unknown operators are swallowed
   assign tok_ok = (func <= i2p_pkg::FUNC_END) &&
                   !((func == i2p_pkg::FUNC_OPER) && (sym > i2p_pkg::OP_POWER));

   assign unary = (sym == i2p_pkg::OP_MINUS) &&
                  ((prev_ff == PREV_NONE) || (prev_ff == PREV_LBR) ||
                   (prev_ff == PREV_OPER));

   assign q_wr_en = take && tok_ok;

   always_comb begin
      prev_in          = prev_ff;
      q_wr_data.code   = i2p_pkg::CMD_END;
      q_wr_data.op     = sym;
      q_wr_data.opnd   = req_tdata[i2p_pkg::OP_W +: i2p_pkg::REF_W];
      unique case (func)
         i2p_pkg::FUNC_OPND: begin
            q_wr_data.code = i2p_pkg::CMD_OPND;
            prev_in        = PREV_OPND;
         end
         i2p_pkg::FUNC_OPER: begin
            q_wr_data.code = i2p_pkg::CMD_OPER;
            q_wr_data.op   = unary ? i2p_pkg::OP_NEG : sym;
            prev_in        = PREV_OPER;
         end
         i2p_pkg::FUNC_LBR: begin
            q_wr_data.code = i2p_pkg::CMD_LBR;
            prev_in        = PREV_LBR;
         end
         i2p_pkg::FUNC_RBR: begin
            q_wr_data.code = i2p_pkg::CMD_RBR;
            prev_in        = PREV_RBR;
         end
         default: begin
            q_wr_data.code = i2p_pkg::CMD_END;
            prev_in        = PREV_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= PREV_NONE;
      end else if (q_wr_en) begin
         prev_ff <= prev_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/i2p_queue.sv
// ----------------------------------------------------------------------------
// i2p_queue
// short command queue between the token front end and the stack engine
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire i2p_pkg::cmd_type wr_data,
   output logic                  full,
   input  wire logic             rd_en,
   output i2p_pkg::cmd_type      rd_data,
   output logic                  rd_valid
);

   localparam int PTR_W = (i2p_pkg::QUEUE_DEPTH > 1) ? $clog2(i2p_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(i2p_pkg::QUEUE_DEPTH + 1);

   i2p_pkg::cmd_type entry_ff [i2p_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_wr;
   logic             do_rd;

   assign full     = (fill_ff == CNT_W'(i2p_pkg::QUEUE_DEPTH));
   assign rd_valid = (fill_ff != '0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(i2p_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(i2p_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/i2p_back.sv
// ----------------------------------------------------------------------------
// i2p_back
// operator stack engine: runs one queued command a step at a time and
// drives the result register
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_back #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire i2p_pkg::cmd_type                q_data,
   output logic                                 q_rd_en,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [i2p_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [i2p_pkg::KIND_W-1:0]           rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   i2p_pkg::cmd_type cur_ff, cur_in;

   // top of stack lives in a register, the entries below it in memory
   logic [i2p_pkg::OP_W-1:0] stack_mem [STACK_DEPTH];

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [i2p_pkg::OP_W-1:0]  top_ff, top_in;
   logic [i2p_pkg::OP_W-1:0]  rd_q_ff;
   logic                      rd_ok_ff, rd_ok_in;
   logic                      err_ff, err_in;

   logic                      out_valid_ff, out_valid_in;
   logic [i2p_pkg::KIND_W-1:0] out_kind_ff, out_kind_in;
   logic [i2p_pkg::OP_W-1:0]  out_op_ff, out_op_in;
   logic [i2p_pkg::REF_W-1:0] out_ref_ff, out_ref_in;
   logic                      out_last_ff, out_last_in;

   logic                      slot_free;
   logic                      have;
   logic                      two;
   logic                      full;
   logic                      top_lbr;
   logic                      oper_pop;
   logic                      oper_more;
   logic                      rbr_last;
   logic                      emit;
   logic [i2p_pkg::KIND_W-1:0] e_kind;
   logic [i2p_pkg::OP_W-1:0]  e_op;
   logic [i2p_pkg::REF_W-1:0] e_ref;
   logic                      e_last;
   logic                      do_pop;
   logic                      do_push;
   logic [i2p_pkg::OP_W-1:0]  push_val;
   logic                      clear;
   logic                      finish;
   logic                      mem_we;
   logic [CNT_W-1:0]          cnt_m1;
   logic [CNT_W-1:0]          cnt_m2;
   logic [ADDR_W-1:0]         wr_addr;
   logic [ADDR_W-1:0]         rd_addr;

   assign slot_free = !out_valid_ff || rsp_tready;
   assign have      = (count_ff != '0);
   assign two       = (count_ff > CNT_W'(1));
   assign full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign top_lbr   = (top_ff == i2p_pkg::OP_LBR);
   assign oper_pop  = have && i2p_pkg::pops(cur_ff.op, top_ff);
   // a further pop follows only if the entry below the top also leaves
   assign oper_more = two && i2p_pkg::pops(cur_ff.op, rd_q_ff);
   assign rbr_last  = two && (rd_q_ff == i2p_pkg::OP_LBR);

   assign cnt_m1  = count_ff - CNT_W'(1);
   assign cnt_m2  = count_ff - CNT_W'(2);
   assign wr_addr = cnt_m1[ADDR_W-1:0];
   assign rd_addr = cnt_m2[ADDR_W-1:0];

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      q_rd_en  = 1'b0;
      emit     = 1'b0;
      e_kind   = i2p_pkg::KIND_OPND;
      e_op     = i2p_pkg::OP_PLUS;
      e_ref    = '0;
      e_last   = 1'b0;
      do_pop   = 1'b0;
      do_push  = 1'b0;
      push_val = cur_ff.op;
      clear    = 1'b0;
      finish   = 1'b0;
      err_in   = err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            q_rd_en = q_valid;
            if (q_valid) begin
               cur_in   = q_data;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // after every stack move, wait for the registered memory read (rd_ok_ff)
            if (rd_ok_ff) begin
               unique case (cur_ff.code)
                  i2p_pkg::CMD_OPND: begin
                     if (err_ff) begin
                        finish = 1'b1;
                     end else if (slot_free) begin
                        emit   = 1'b1;
                        e_kind = i2p_pkg::KIND_OPND;
                        e_ref  = cur_ff.opnd;
                        e_last = 1'b1;
                        finish = 1'b1;
                     end
                  end
                  i2p_pkg::CMD_OPER, i2p_pkg::CMD_LBR: begin
                     push_val = (cur_ff.code == i2p_pkg::CMD_LBR) ? i2p_pkg::OP_LBR
                                                                  : cur_ff.op;
                     if (err_ff) begin
                        finish = 1'b1;
                     end else if ((cur_ff.code == i2p_pkg::CMD_OPER) && oper_pop) begin
                        if (slot_free) begin
                           emit   = 1'b1;
                           e_kind = i2p_pkg::KIND_OPER;
                           e_op   = top_ff;
                           e_last = !oper_more;
                           do_pop = 1'b1;
                        end
                     end else if (full) begin
                        if (slot_free) begin
                           emit   = 1'b1;
                           e_kind = i2p_pkg::KIND_ERR;
                           e_last = 1'b1;
                           err_in = 1'b1;
                           finish = 1'b1;
                        end
                     end else begin
                        do_push = 1'b1;
                        finish  = 1'b1;
                     end
                  end
                  i2p_pkg::CMD_RBR: begin
                     if (err_ff) begin
                        finish = 1'b1;
                     end else if (!have) begin
                        if (slot_free) begin
                           emit   = 1'b1;
                           e_kind = i2p_pkg::KIND_ERR;
                           e_last = 1'b1;
                           err_in = 1'b1;
                           finish = 1'b1;
                        end
                     end else if (top_lbr) begin
                        do_pop = 1'b1;
                        finish = 1'b1;
                     end else if (slot_free) begin
                        emit   = 1'b1;
                        e_kind = i2p_pkg::KIND_OPER;
                        e_op   = top_ff;
                        e_last = rbr_last;
                        do_pop = 1'b1;
                     end
                  end
                  default: begin
                     // end of expression: flush, then done or error
                     if (slot_free) begin
                        emit = 1'b1;
                        if (err_ff || (have && top_lbr)) begin
                           e_kind = i2p_pkg::KIND_ERR;
                           e_last = 1'b1;
                           clear  = 1'b1;
                           finish = 1'b1;
                        end else if (!have) begin
                           e_kind = i2p_pkg::KIND_DONE;
                           e_last = 1'b1;
                           clear  = 1'b1;
                           finish = 1'b1;
                        end else begin
                           e_kind = i2p_pkg::KIND_OPER;
                           e_op   = top_ff;
                           do_pop = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (finish) begin
         state_in = ST_IDLE;
      end
      if (clear) begin
         err_in = 1'b0;
      end
   end

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      priority if (clear) begin
         count_in = '0;
      end else if (do_pop) begin
         count_in = cnt_m1;
         top_in   = rd_q_ff;
      end else if (do_push) begin
         count_in = count_ff + CNT_W'(1);
         top_in   = push_val;
      end
      rd_ok_in = !(clear || do_pop || do_push);
      mem_we = do_push && have;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_op_in    = out_op_ff;
      out_ref_in   = out_ref_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = e_kind;
         out_op_in    = e_op;
         out_ref_in   = e_ref;
         out_last_in  = e_last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         err_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_ok_ff     <= rd_ok_in;
         err_ff       <= err_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      top_ff      <= top_in;
      out_kind_ff <= out_kind_in;
      out_op_ff   <= out_op_in;
      out_ref_ff  <= out_ref_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_addr] <= top_ff;
      end
      rd_q_ff <= stack_mem[rd_addr];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(i2p_pkg::RSP_DATA_W - i2p_pkg::OP_W - i2p_pkg::REF_W){1'b0}},
                        out_ref_ff, out_op_ff};

endmodule

`default_nettype wire

// File: rtl/core/i2p_checker.sv
// ----------------------------------------------------------------------------
// i2p_checker
// port-level checks on the converter's result stream
// ----------------------------------------------------------------------------
`default_nettype none

module i2p_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [i2p_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [i2p_pkg::KIND_W-1:0]      rsp_tuser,
   input wire logic                            rsp_tlast
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // operator field only set on operator beats
   a_op_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != i2p_pkg::KIND_OPER) |->
         rsp_tdata[i2p_pkg::OP_W-1:0] == '0)
      else $error("operator field set on a non-operator beat");

   // handle field only set on operand beats
   a_ref_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != i2p_pkg::KIND_OPND) |->
         rsp_tdata[i2p_pkg::OP_W +: i2p_pkg::REF_W] == '0)
      else $error("handle field set on a non-operand beat");

   // operands, done and error always close their token's run
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != i2p_pkg::KIND_OPER) |-> rsp_tlast)
      else $error("non-operator beat without tlast");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
